// ===== sv/p2oc_pkg.sv =====
`default_nettype none

package p2oc_pkg;

    localparam int MAX_DIM      = 4096;
    localparam int MAX_CHANNELS = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int DIM_W      = 13;
    localparam int THR_W      = 17;
    localparam int QUOT_W     = 7;
    localparam int PRE_STAGES = 4;
    localparam int NUM_STAGES = PRE_STAGES + QUOT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PRESENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONV_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_COLOUR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OCC_THRESHOLD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_THRESHOLD = 3'd7;

    localparam logic [1:0] MODE_TRINARY = 2'd0;
    localparam logic [1:0] MODE_SCALE   = 2'd1;
    localparam logic [1:0] MODE_RAW     = 2'd2;

    localparam logic [7:0] VALUE_OCCUPIED = 8'd100;
    localparam logic [7:0] VALUE_FREE     = 8'd0;
    localparam logic [7:0] VALUE_UNKNOWN  = 8'd255;
    localparam logic [6:0] SCALE_MAX      = 7'd99;

    localparam logic [THR_W-1:0] OCC_THRESHOLD_RESET  = 17'd42598;
    localparam logic [THR_W-1:0] FREE_THRESHOLD_RESET = 17'd12452;

    // Full-scale sum of the averaged channels.
    function automatic logic [9:0] avg_den(input logic [2:0] navg);
        logic [9:0] den;
        case (navg)
            3'd1: den = 10'd255;
            3'd2: den = 10'd510;
            3'd3: den = 10'd765;
            3'd4: den = 10'd1020;
            default: den = 10'd255;
        endcase
        return den;
    endfunction

    // Reciprocal floor(2^36 / den), always an underestimate by under one.
    function automatic logic [28:0] avg_recip(input logic [2:0] navg);
        logic [28:0] rcp;
        case (navg)
            3'd1: rcp = 29'd269488144;
            3'd2: rcp = 29'd134744072;
            3'd3: rcp = 29'd89829381;
            3'd4: rcp = 29'd67372036;
            default: rcp = 29'd269488144;
        endcase
        return rcp;
    endfunction

    // Multiplier for floor(g / navg) as (g * k) >> 11, exact for g up to 255 * navg.
    function automatic logic [11:0] raw_mult(input logic [2:0] navg);
        logic [11:0] k;
        case (navg)
            3'd1: k = 12'd2048;
            3'd2: k = 12'd1024;
            3'd3: k = 12'd683;
            3'd4: k = 12'd512;
            default: k = 12'd2048;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pixel_to_occupancy_cell.sv =====
// Pixel to occupancy cell converter.
// Input channel: i_valid / o_stall carry one pixel per item (plane, column, row
// and up to four channel bytes). Output channel: o_valid / i_stall carry one map
// cell per item (plane, flipped cell index and cell value). An item moves at a
// rising edge where valid is high and stall is low.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data, one
// register per cycle; the user must write it only while no item is in flight,
// which the block itself does not enforce. There are four arithmetic stages
// (channel sum, reciprocal multiply, remainder correction, classification)
// and a seven-stage restoring divider forming the scaled occupancy one quotient
// bit per stage. Throughput is one item per cycle while the receiver is ready.
// Each stage holds a valid bit; a stage advances whenever it is empty or the
// stage after it advances, so bubbles are squeezed out while the receiver
// stalls and the block keeps accepting items until all eleven stages are full.
// Synchronous reset empties the pipeline and restores the register defaults:
// width and height one, one channel, no alpha, trinary mode, no inversion and
// thresholds of 0.65 and 0.19 in Q1.16.
`default_nettype none

module pixel_to_occupancy_cell (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_plane,
    input  logic [11:0] i_column,
    input  logic [11:0] i_image_row,
    input  logic [7:0]  i_chan_a,
    input  logic [7:0]  i_chan_b,
    input  logic [7:0]  i_chan_c,
    input  logic [7:0]  i_chan_d,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_plane,
    output logic [23:0] o_cell_index,
    output logic [7:0]  o_cell_value
);

    localparam int NST = p2oc_pkg::NUM_STAGES;
    localparam int QW  = p2oc_pkg::QUOT_W;

    logic [12:0] r_map_width;
    logic [12:0] r_map_height;
    logic [2:0]  r_chan_count;
    logic        r_alpha;
    logic [1:0]  r_mode;
    logic        r_invert;
    logic [16:0] r_occ_th;
    logic [16:0] r_free_th;

    logic [NST-1:0] r_vld;
    logic [NST:0]   w_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 13'd1;
            r_map_height <= 13'd1;
            r_chan_count <= 3'd1;
            r_alpha      <= 1'b0;
            r_mode       <= p2oc_pkg::MODE_TRINARY;
            r_invert     <= 1'b0;
            r_occ_th     <= p2oc_pkg::OCC_THRESHOLD_RESET;
            r_free_th    <= p2oc_pkg::FREE_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                p2oc_pkg::CFG_MAP_WIDTH:      r_map_width  <= i_cfg_data[12:0];
                p2oc_pkg::CFG_MAP_HEIGHT:     r_map_height <= i_cfg_data[12:0];
                p2oc_pkg::CFG_CHANNEL_COUNT:  r_chan_count <= i_cfg_data[2:0];
                p2oc_pkg::CFG_ALPHA_PRESENT:  r_alpha      <= i_cfg_data[0];
                p2oc_pkg::CFG_CONV_MODE:      r_mode       <= i_cfg_data[1:0];
                p2oc_pkg::CFG_INVERT_COLOUR:  r_invert     <= i_cfg_data[0];
                p2oc_pkg::CFG_OCC_THRESHOLD:  r_occ_th     <= i_cfg_data;
                p2oc_pkg::CFG_FREE_THRESHOLD: r_free_th    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_rdy[NST] = !i_stall;
        for (int k = NST - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: channel selection, sum, inversion and row flip.
    logic [2:0]  w_nch;
    logic [2:0]  w_navg;
    logic [9:0]  w_sum;
    logic [7:0]  w_alpha_byte;
    logic [9:0]  w_den0;
    logic [9:0]  w_g;
    logic [12:0] w_h;

    always_comb begin
        if (r_chan_count == 3'd0) begin
            w_nch = 3'd1;
        end else if (r_chan_count > 3'(p2oc_pkg::MAX_CHANNELS)) begin
            w_nch = 3'(p2oc_pkg::MAX_CHANNELS);
        end else begin
            w_nch = r_chan_count;
        end
        if (r_mode == p2oc_pkg::MODE_TRINARY || !r_alpha || w_nch == 3'd1) begin
            w_navg = w_nch;
        end else begin
            w_navg = w_nch - 3'd1;
        end
        w_sum = {2'b00, i_chan_a}
              + ((w_navg >= 3'd2) ? {2'b00, i_chan_b} : 10'd0)
              + ((w_navg >= 3'd3) ? {2'b00, i_chan_c} : 10'd0)
              + ((w_navg >= 3'd4) ? {2'b00, i_chan_d} : 10'd0);
        case (w_nch)
            3'd2: w_alpha_byte = i_chan_b;
            3'd3: w_alpha_byte = i_chan_c;
            3'd4: w_alpha_byte = i_chan_d;
            default: w_alpha_byte = i_chan_a;
        endcase
        w_den0 = p2oc_pkg::avg_den(w_navg);
        w_g    = r_invert ? (w_den0 - w_sum) : w_sum;
        if (int'(r_map_height) > p2oc_pkg::MAX_DIM) begin
            w_h = 13'(p2oc_pkg::MAX_DIM);
        end else begin
            w_h = r_map_height;
        end
    end

    logic [1:0]  r_s0_plane;
    logic [11:0] r_s0_col;
    logic [23:0] r_s0_flip;
    logic [9:0]  r_s0_x;
    logic [9:0]  r_s0_g;
    logic [2:0]  r_s0_navg;
    logic        r_s0_azero;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s0_plane <= i_plane;
            r_s0_col   <= i_column;
            r_s0_flip  <= 24'(w_h) - 24'd1 - 24'(i_image_row);
            r_s0_x     <= w_den0 - w_g;
            r_s0_g     <= w_g;
            r_s0_navg  <= w_navg;
            r_s0_azero <= (w_nch != 3'd1) && (w_alpha_byte == 8'd0);
        end
    end

    // Stage 1: reciprocal estimate of the occupancy, raw grey and row offset.
    logic [25:0] w_num1;
    logic [54:0] w_qprod;
    logic [21:0] w_rawprod;
    logic [12:0] w_w;
    logic [36:0] w_iprod;

    always_comb begin
        w_num1    = {r_s0_x, 16'd0};
        w_qprod   = w_num1 * p2oc_pkg::avg_recip(r_s0_navg);
        w_rawprod = r_s0_g * p2oc_pkg::raw_mult(r_s0_navg);
        if (int'(r_map_width) > p2oc_pkg::MAX_DIM) begin
            w_w = 13'(p2oc_pkg::MAX_DIM);
        end else begin
            w_w = r_map_width;
        end
        w_iprod = w_w * r_s0_flip;
    end

    logic [1:0]  r_s1_plane;
    logic [11:0] r_s1_col;
    logic [16:0] r_s1_qest;
    logic [9:0]  r_s1_x;
    logic [2:0]  r_s1_navg;
    logic        r_s1_azero;
    logic [7:0]  r_s1_raw;
    logic [23:0] r_s1_iprod;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s1_plane <= r_s0_plane;
            r_s1_col   <= r_s0_col;
            r_s1_qest  <= w_qprod[52:36];
            r_s1_x     <= r_s0_x;
            r_s1_navg  <= r_s0_navg;
            r_s1_azero <= r_s0_azero;
            r_s1_raw   <= w_rawprod[18:11];
            r_s1_iprod <= w_iprod[23:0];
        end
    end

    // Stage 2: remainder check corrects the estimate by at most one.
    logic [9:0]  w_den2;
    logic [26:0] w_qd;
    logic [26:0] w_rem2;

    always_comb begin
        w_den2 = p2oc_pkg::avg_den(r_s1_navg);
        w_qd   = r_s1_qest * w_den2;
        w_rem2 = {1'b0, r_s1_x, 16'd0} - w_qd;
    end

    logic [1:0]  r_s2_plane;
    logic [23:0] r_s2_idx;
    logic [16:0] r_s2_occ;
    logic        r_s2_azero;
    logic [7:0]  r_s2_raw;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s2_plane <= r_s1_plane;
            r_s2_idx   <= r_s1_iprod + 24'(r_s1_col);
            r_s2_occ   <= r_s1_qest + 17'(w_rem2 >= 27'(w_den2));
            r_s2_azero <= r_s1_azero;
            r_s2_raw   <= r_s1_raw;
        end
    end

    // Stage 3: classification against the thresholds, or the raw grey in raw mode.
    logic [16:0] w_diff;
    logic [23:0] w_num3;
    logic [7:0]  w_value3;
    logic        w_div3;
    logic [16:0] w_dsr;

    always_comb begin
        w_diff   = r_s2_occ - r_free_th;
        w_num3   = w_diff * p2oc_pkg::SCALE_MAX;
        w_dsr    = r_occ_th - r_free_th;
        w_value3 = p2oc_pkg::VALUE_FREE;
        w_div3   = 1'b0;
        if (r_mode == p2oc_pkg::MODE_RAW) begin
            w_value3 = r_s2_raw;
        end else if (r_s2_occ > r_occ_th) begin
            w_value3 = p2oc_pkg::VALUE_OCCUPIED;
        end else if (r_s2_occ < r_free_th) begin
            w_value3 = p2oc_pkg::VALUE_FREE;
        end else if (r_mode == p2oc_pkg::MODE_TRINARY || r_s2_azero) begin
            w_value3 = p2oc_pkg::VALUE_UNKNOWN;
        end else if (r_occ_th <= r_free_th) begin
            w_value3 = p2oc_pkg::VALUE_FREE;
        end else begin
            w_div3 = 1'b1;
        end
    end

    logic [1:0]  r_s3_plane;
    logic [23:0] r_s3_idx;
    logic [7:0]  r_s3_value;
    logic        r_s3_div;
    logic [23:0] r_s3_num;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s3_plane <= r_s2_plane;
            r_s3_idx   <= r_s2_idx;
            r_s3_value <= w_value3;
            r_s3_div   <= w_div3;
            r_s3_num   <= w_num3;
        end
    end

    // Divider stages: one quotient bit each, most significant first.
    logic [1:0]    r_dv_plane [QW];
    logic [23:0]   r_dv_idx   [QW];
    logic [7:0]    r_dv_value [QW];
    logic          r_dv_div   [QW];
    logic [23:0]   r_dv_rem   [QW];
    logic [QW-1:0] r_dv_q     [QW];

    logic [23:0]   n_dv_rem   [QW];
    logic [QW-1:0] n_dv_q     [QW];

    always_comb begin
        logic [23:0]   rem_in;
        logic [QW-1:0] q_in;
        logic [23:0]   dsh;
        for (int j = 0; j < QW; j++) begin
            rem_in = (j == 0) ? r_s3_num : r_dv_rem[(j == 0) ? 0 : j - 1];
            q_in   = (j == 0) ? '0 : r_dv_q[(j == 0) ? 0 : j - 1];
            dsh    = 24'(w_dsr) << (QW - 1 - j);
            if (rem_in >= dsh) begin
                n_dv_rem[j] = rem_in - dsh;
                n_dv_q[j]   = q_in | (QW'(1) << (QW - 1 - j));
            end else begin
                n_dv_rem[j] = rem_in;
                n_dv_q[j]   = q_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QW; j++) begin
            if (w_rdy[p2oc_pkg::PRE_STAGES + j]) begin
                r_dv_rem[j] <= n_dv_rem[j];
                r_dv_q[j]   <= n_dv_q[j];
                if (j == 0) begin
                    r_dv_plane[j] <= r_s3_plane;
                    r_dv_idx[j]   <= r_s3_idx;
                    r_dv_value[j] <= r_s3_value;
                    r_dv_div[j]   <= r_s3_div;
                end else begin
                    r_dv_plane[j] <= r_dv_plane[(j == 0) ? 0 : j - 1];
                    r_dv_idx[j]   <= r_dv_idx[(j == 0) ? 0 : j - 1];
                    r_dv_value[j] <= r_dv_value[(j == 0) ? 0 : j - 1];
                    r_dv_div[j]   <= r_dv_div[(j == 0) ? 0 : j - 1];
                end
            end
        end
    end

    assign o_stall      = !w_rdy[0];
    assign o_valid      = r_vld[NST-1];
    assign o_out_plane  = r_dv_plane[QW-1];
    assign o_cell_index = r_dv_idx[QW-1];
    assign o_cell_value = r_dv_div[QW-1] ? 8'(r_dv_q[QW-1]) : r_dv_value[QW-1];

endmodule

`default_nettype wire

// ===== sv/p2oc_checker.sv =====
`default_nettype none

module p2oc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_out_plane,
    input logic [23:0] o_cell_index,
    input logic [7:0]  o_cell_value
);

    // A reset cycle leaves the output channel empty.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // With the receiver ready every stage can advance, so no item is refused.
    a_no_stall_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output side is ready");

    // An empty output stage can always take the next item.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output stage is empty");

    // A stalled result stays in place unchanged.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_plane)
            && $stable(o_cell_index) && $stable(o_cell_value))
        else $error("stalled item changed or dropped");

endmodule

bind pixel_to_occupancy_cell p2oc_checker u_p2oc_checker (.*);

`default_nettype wire

// ===== tb/occupancy_cell_monitor.sv =====
`timescale 1ns / 100ps

module occupancy_cell_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_pix_valid,
    input  logic        i_pix_stall,
    input  logic [1:0]  i_plane,
    input  logic [11:0] i_column,
    input  logic [11:0] i_image_row,
    input  logic [7:0]  i_chan_a,
    input  logic [7:0]  i_chan_b,
    input  logic [7:0]  i_chan_c,
    input  logic [7:0]  i_chan_d,
    input  logic        i_cell_valid,
    input  logic        i_cell_stall,
    input  logic [1:0]  i_out_plane,
    input  logic [23:0] i_cell_index,
    input  logic [7:0]  i_cell_value,
    output int          o_mismatches,
    output int          o_cells_outstanding
);

    typedef struct packed {
        logic [1:0]  plane;
        logic [23:0] index;
        logic [7:0]  value;
    } t_cell;

    logic [12:0]                cfg_width;
    logic [12:0]                cfg_height;
    logic [2:0]                 cfg_channels;
    logic                       cfg_alpha;
    logic [1:0]                 cfg_mode;
    logic                       cfg_invert;
    logic [p2oc_pkg::THR_W-1:0] cfg_occ_thr;
    logic [p2oc_pkg::THR_W-1:0] cfg_free_thr;

    t_cell cells_due[$];
    t_cell want;
    int    mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic t_cell predict_cell(input logic [1:0] plane, input logic [11:0] column,
                                           input logic [11:0] image_row,
                                           input logic [7:0] chan_a, input logic [7:0] chan_b,
                                           input logic [7:0] chan_c, input logic [7:0] chan_d);
        logic [7:0]  chans [0:3];
        logic [2:0]  n_ch;
        logic [2:0]  n_avg;
        logic [9:0]  total;
        logic [9:0]  full;
        logic [9:0]  grey;
        logic [7:0]  alpha;
        logic [26:0] scaled;
        logic [16:0] occ;
        logic [12:0] w;
        logic [12:0] h;
        logic [23:0] flipped;
        int          k;
        t_cell       pred;

        chans[0] = chan_a;
        chans[1] = chan_b;
        chans[2] = chan_c;
        chans[3] = chan_d;

        if (cfg_channels == 3'd0) begin
            n_ch = 3'd1;
        end else if (cfg_channels > 3'(p2oc_pkg::MAX_CHANNELS)) begin
            n_ch = 3'(p2oc_pkg::MAX_CHANNELS);
        end else begin
            n_ch = cfg_channels;
        end

        // The alpha byte only joins the average in trinary mode or when it is not alpha.
        if (cfg_mode == p2oc_pkg::MODE_TRINARY || !cfg_alpha || n_ch == 3'd1) begin
            n_avg = n_ch;
        end else begin
            n_avg = n_ch - 3'd1;
        end

        total = '0;
        for (k = 0; k < n_avg; k++) begin
            total += 10'(chans[k]);
        end
        alpha = (n_ch == 3'd1) ? 8'd1 : chans[n_ch - 3'd1];
        full  = 10'(n_avg) * 10'd255;
        grey  = cfg_invert ? full - total : total;

        pred.plane = plane;
        if (cfg_mode == p2oc_pkg::MODE_RAW) begin
            pred.value = 8'(grey / 10'(n_avg));
        end else begin
            scaled = 27'(full - grey) << 16;
            occ    = 17'(scaled / 27'(full));
            if (occ > cfg_occ_thr) begin
                pred.value = p2oc_pkg::VALUE_OCCUPIED;
            end else if (occ < cfg_free_thr) begin
                pred.value = p2oc_pkg::VALUE_FREE;
            end else if (cfg_mode == p2oc_pkg::MODE_TRINARY || alpha == 8'd0) begin
                pred.value = p2oc_pkg::VALUE_UNKNOWN;
            end else if (cfg_occ_thr <= cfg_free_thr) begin
                pred.value = p2oc_pkg::VALUE_FREE;
            end else begin
                pred.value = 8'(32'(p2oc_pkg::SCALE_MAX) * 32'(occ - cfg_free_thr)
                                / 32'(cfg_occ_thr - cfg_free_thr));
            end
        end

        w = (cfg_width > 13'(p2oc_pkg::MAX_DIM)) ? 13'(p2oc_pkg::MAX_DIM) : cfg_width;
        h = (cfg_height > 13'(p2oc_pkg::MAX_DIM)) ? 13'(p2oc_pkg::MAX_DIM) : cfg_height;
        // Cell row zero is the bottom image row; rows past the height wrap round.
        flipped    = 24'(h) - 24'd1 - 24'(image_row);
        pred.index = 24'(w) * flipped + 24'(column);
        return pred;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width    = 13'd1;
            cfg_height   = 13'd1;
            cfg_channels = 3'd1;
            cfg_alpha    = 1'b0;
            cfg_mode     = p2oc_pkg::MODE_TRINARY;
            cfg_invert   = 1'b0;
            cfg_occ_thr  = p2oc_pkg::OCC_THRESHOLD_RESET;
            cfg_free_thr = p2oc_pkg::FREE_THRESHOLD_RESET;
            cells_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    p2oc_pkg::CFG_MAP_WIDTH:      cfg_width    = i_cfg_data[12:0];
                    p2oc_pkg::CFG_MAP_HEIGHT:     cfg_height   = i_cfg_data[12:0];
                    p2oc_pkg::CFG_CHANNEL_COUNT:  cfg_channels = i_cfg_data[2:0];
                    p2oc_pkg::CFG_ALPHA_PRESENT:  cfg_alpha    = i_cfg_data[0];
                    p2oc_pkg::CFG_CONV_MODE:      cfg_mode     = i_cfg_data[1:0];
                    p2oc_pkg::CFG_INVERT_COLOUR:  cfg_invert   = i_cfg_data[0];
                    p2oc_pkg::CFG_OCC_THRESHOLD:  cfg_occ_thr  = i_cfg_data;
                    p2oc_pkg::CFG_FREE_THRESHOLD: cfg_free_thr = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pix_valid && !i_pix_stall) begin
                cells_due.push_back(predict_cell(i_plane, i_column, i_image_row,
                                                 i_chan_a, i_chan_b, i_chan_c, i_chan_d));
            end
            if (i_cell_valid && !i_cell_stall) begin
                if (cells_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected cell: plane %0d index %0d value %0d",
                                              i_out_plane, i_cell_index, i_cell_value));
                end else begin
                    want = cells_due.pop_front();
                    if (i_out_plane !== want.plane) begin
                        report_mismatch($sformatf("plane: expected %0d, got %0d",
                                                  want.plane, i_out_plane));
                    end
                    if (i_cell_index !== want.index) begin
                        report_mismatch($sformatf("cell index: expected %0d, got %0d",
                                                  want.index, i_cell_index));
                    end
                    if (i_cell_value !== want.value) begin
                        report_mismatch($sformatf("cell value at index %0d: expected %0d, got %0d",
                                                  want.index, want.value, i_cell_value));
                    end
                end
            end
        end
        o_cells_outstanding <= cells_due.size();
    end

endmodule

// ===== tb/pixel_to_occupancy_cell_tb.sv =====
`timescale 1ns / 100ps

module pixel_to_occupancy_cell_tb;

    localparam logic [1:0] MODE_SPARE     = 2'd3;
    localparam int         Q16_ONE        = 65536;
    localparam int         RANDOM_PIXELS  = 400;
    localparam int         CALM_FROM      = 340;
    localparam int         WATCHDOG_LIMIT = 1000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [16:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_plane;
    logic [11:0] i_column;
    logic [11:0] i_image_row;
    logic [7:0]  i_chan_a;
    logic [7:0]  i_chan_b;
    logic [7:0]  i_chan_c;
    logic [7:0]  i_chan_d;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_out_plane;
    logic [23:0] o_cell_index;
    logic [7:0]  o_cell_value;

    int   mismatches;
    int   cells_outstanding;
    int   idle_cycles = 0;
    int   gap_odds;
    int   rows_in_map;
    logic calm;

    pixel_to_occupancy_cell dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_plane      (i_plane),
        .i_column     (i_column),
        .i_image_row  (i_image_row),
        .i_chan_a     (i_chan_a),
        .i_chan_b     (i_chan_b),
        .i_chan_c     (i_chan_c),
        .i_chan_d     (i_chan_d),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_plane  (o_out_plane),
        .o_cell_index (o_cell_index),
        .o_cell_value (o_cell_value)
    );

    occupancy_cell_monitor monitor (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_pix_valid         (i_valid),
        .i_pix_stall         (o_stall),
        .i_plane             (i_plane),
        .i_column            (i_column),
        .i_image_row         (i_image_row),
        .i_chan_a            (i_chan_a),
        .i_chan_b            (i_chan_b),
        .i_chan_c            (i_chan_c),
        .i_chan_d            (i_chan_d),
        .i_cell_valid        (o_valid),
        .i_cell_stall        (i_stall),
        .i_out_plane         (o_out_plane),
        .i_cell_index        (o_cell_index),
        .i_cell_value        (o_cell_value),
        .o_mismatches        (mismatches),
        .o_cells_outstanding (cells_outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver stalls in bursts, with longer free-running stretches in between.
    initial begin
        int run;
        i_stall = 1'b0;
        forever begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 18);
            repeat (run) @(posedge i_clk);
            if (!calm) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_pixel(input logic [1:0] plane, input logic [11:0] column,
                              input logic [11:0] image_row, input logic [7:0] chan_a,
                              input logic [7:0] chan_b, input logic [7:0] chan_c,
                              input logic [7:0] chan_d);
        if (!calm && $urandom_range(0, 99) < gap_odds) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_plane     <= plane;
        i_column    <= column;
        i_image_row <= image_row;
        i_chan_a    <= chan_a;
        i_chan_b    <= chan_b;
        i_chan_c    <= chan_c;
        i_chan_d    <= chan_d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (cells_outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [16:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic set_registers(input int width, input int height, input int channels,
                                 input int alpha, input int mode, input int invert,
                                 input int occ_thr, input int free_thr);
        write_reg(p2oc_pkg::CFG_MAP_WIDTH, 17'(width));
        write_reg(p2oc_pkg::CFG_MAP_HEIGHT, 17'(height));
        write_reg(p2oc_pkg::CFG_CHANNEL_COUNT, 17'(channels));
        write_reg(p2oc_pkg::CFG_ALPHA_PRESENT, 17'(alpha));
        write_reg(p2oc_pkg::CFG_CONV_MODE, 17'(mode));
        write_reg(p2oc_pkg::CFG_INVERT_COLOUR, 17'(invert));
        write_reg(p2oc_pkg::CFG_OCC_THRESHOLD, 17'(occ_thr));
        write_reg(p2oc_pkg::CFG_FREE_THRESHOLD, 17'(free_thr));
        i_cfg_we    <= 1'b0;
        rows_in_map = height;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_threshold();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return Q16_ONE;
            2: return $urandom_range(Q16_ONE + 1, 131071);
            default: return $urandom_range(0, Q16_ONE);
        endcase
    endfunction

    initial begin
        int          sent;
        int          phase_len;
        int          wid;
        int          hgt;
        int          channels;
        int          mode;
        int          thr_a;
        int          thr_b;
        int          occ_thr;
        int          free_thr;
        logic [11:0] row;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_plane     = '0;
        i_column    = '0;
        i_image_row = '0;
        i_chan_a    = '0;
        i_chan_b    = '0;
        i_chan_c    = '0;
        i_chan_d    = '0;
        calm        = 1'b0;
        gap_odds    = 30;
        rows_in_map = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register values straight out of reset.
        send_pixel(0, 0, 0, 0, 0, 0, 0);
        send_pixel(3, 4095, 0, 255, 0, 0, 0);
        send_pixel(1, 1, 1, 128, 255, 255, 255);
        settle();

        // Largest map, alpha excluded from the average, thresholds at one and zero.
        set_registers(p2oc_pkg::MAX_DIM, p2oc_pkg::MAX_DIM, 4, 1, p2oc_pkg::MODE_SCALE, 0,
                      Q16_ONE, 0);
        send_pixel(2, 4095, 0, 255, 255, 255, 255);
        send_pixel(0, 0, 4095, 0, 0, 0, 255);
        send_pixel(1, 100, 200, 10, 20, 30, 0);
        send_pixel(3, 4095, 4095, 200, 100, 50, 128);
        settle();

        set_registers(p2oc_pkg::MAX_DIM, p2oc_pkg::MAX_DIM, 3, 0, p2oc_pkg::MODE_RAW, 1,
                      p2oc_pkg::OCC_THRESHOLD_RESET, p2oc_pkg::FREE_THRESHOLD_RESET);
        send_pixel(0, 0, 0, 0, 0, 0, 0);
        send_pixel(1, 2047, 2048, 255, 255, 255, 0);
        send_pixel(2, 1, 4094, 1, 2, 4, 255);
        settle();

        // Equal thresholds, hit exactly by a mid grey.
        set_registers(1000, 500, 2, 1, p2oc_pkg::MODE_SCALE, 0, 32639, 32639);
        send_pixel(0, 999, 499, 128, 77, 0, 0);
        send_pixel(3, 0, 0, 0, 9, 0, 0);
        settle();

        // One channel flagged as alpha, oversized width, rows beyond the height.
        set_registers(8191, 2, 1, 1, p2oc_pkg::MODE_SCALE, 1, 50000, 10000);
        send_pixel(1, 17, 0, 100, 0, 0, 0);
        send_pixel(2, 4095, 4095, 0, 0, 0, 0);
        send_pixel(0, 5, 1, 255, 0, 0, 0);
        settle();

        // Channel count zero, the unused mode code and an oversized height.
        set_registers(p2oc_pkg::MAX_DIM, 8191, 0, 1, MODE_SPARE, 0, 131071, Q16_ONE);
        send_pixel(0, 1, 2, 0, 255, 255, 255);
        send_pixel(3, 2, 1, 37, 0, 0, 0);
        settle();

        // Channel count above the maximum, zero thresholds, inverted.
        set_registers(1, 1, 7, 1, p2oc_pkg::MODE_TRINARY, 1, 0, 0);
        send_pixel(1, 0, 0, 0, 0, 0, 0);
        send_pixel(2, 0, 0, 255, 255, 255, 255);
        send_pixel(3, 0, 0, 12, 200, 99, 0);

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            settle();
            calm = (sent >= CALM_FROM);
            case ($urandom_range(0, 2))
                0: gap_odds = 0;
                1: gap_odds = 20;
                default: gap_odds = 60;
            endcase
            case ($urandom_range(0, 5))
                0: wid = 1;
                1: wid = p2oc_pkg::MAX_DIM;
                2: wid = $urandom_range(p2oc_pkg::MAX_DIM + 1, 8191);
                default: wid = $urandom_range(1, p2oc_pkg::MAX_DIM);
            endcase
            case ($urandom_range(0, 9))
                0: hgt = 1;
                1: hgt = p2oc_pkg::MAX_DIM;
                2: hgt = $urandom_range(p2oc_pkg::MAX_DIM + 1, 8191);
                3: hgt = 0;
                default: hgt = $urandom_range(1, p2oc_pkg::MAX_DIM);
            endcase
            channels = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                   : $urandom_range(1, p2oc_pkg::MAX_CHANNELS);
            mode     = ($urandom_range(0, 7) == 0) ? MODE_SPARE : $urandom_range(0, 2);
            thr_a    = pick_threshold();
            thr_b    = pick_threshold();
            if ($urandom_range(0, 3) == 0) begin
                occ_thr  = thr_a;
                free_thr = thr_b;
            end else begin
                occ_thr  = (thr_a > thr_b) ? thr_a : thr_b;
                free_thr = (thr_a > thr_b) ? thr_b : thr_a;
            end
            set_registers(wid, hgt, channels, $urandom_range(0, 1), mode,
                          $urandom_range(0, 1), occ_thr, free_thr);

            phase_len = $urandom_range(10, 40);
            repeat (phase_len) begin
                if (rows_in_map >= 1 && rows_in_map <= p2oc_pkg::MAX_DIM
                        && $urandom_range(0, 7) != 0) begin
                    row = 12'($urandom_range(0, rows_in_map - 1));
                end else begin
                    row = 12'($urandom_range(0, 4095));
                end
                send_pixel(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)), row,
                           rand_byte(), rand_byte(), rand_byte(), rand_byte());
                sent++;
            end
        end

        settle();
        repeat (2 * p2oc_pkg::NUM_STAGES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
